>>> src/spwfd_pkg.sv
// types and constants for the single-wire sensor pulse-width frame decoder
// no dependencies; used by sensor_pulse_width_frame_decoder
package spwfd_pkg;

    // reported read status
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_READING = 2'd1,
        ST_ERROR   = 2'd2
    } status_t;

    // field being shifted in; the unused code behaves like the checksum field
    typedef enum logic [1:0] {
        FLD_HUM   = 2'd0,
        FLD_TEMP  = 2'd1,
        FLD_CSUM  = 2'd2,
        FLD_SPARE = 2'd3
    } field_t;

    // configuration register indexes
    localparam logic [1:0] CFG_RESPONSE_MAX = 2'd0;
    localparam logic [1:0] CFG_BIT_MAX      = 2'd1;
    localparam logic [1:0] CFG_ONE_MIN      = 2'd2;

    localparam logic [15:0] RESPONSE_MAX_RST = 16'd100;
    localparam logic [15:0] BIT_MAX_RST      = 16'd100;
    localparam logic [15:0] ONE_MIN_RST      = 16'd50;

    // first bit position of a 16-bit and of an 8-bit field
    localparam logic [3:0] TOP_BIT16 = 4'd15;
    localparam logic [3:0] TOP_BIT8  = 4'd7;

    // one result beat
    typedef struct packed {
        status_t     status;
        logic [15:0] humidity;
        logic [15:0] temperature;
        logic        frame_done;
    } result_t;

endpackage

>>> src/sensor_pulse_width_frame_decoder.sv
// top level of the single-wire sensor frame decoder: decode logic and output buffering
// depends on spwfd_pkg
//
// Usage:
// - input channel (in_valid / in_stall) carries one beat per pulse: action 1 starts
//   a new read, action 0 delivers a measured high-pulse width in timer ticks
// - the first pulse after a start is the sensor response, then 40 data bits follow
//   (16 humidity, 16 temperature, 8 checksum, msb first)
// - every input beat yields exactly one output beat on out_valid / out_stall with
//   status, the stored humidity and temperature, and frame_done on the last bit
// - accepted beats are registered into the result register; with out_stall low one beat
//   per cycle is sustained, set by the single decode stage between state and result registers
// - when the receiver stalls, the result register holds and one further beat is
//   caught in a skid register; in_stall rises only while that skid register is full
// - reset clears state to finished ok, humidity field at bit 15, zero values, and
//   loads the thresholds with their defaults (response 100, bit 100, one 50)
// - cfg_we writes threshold cfg_index with cfg_data; write only while idle
module sensor_pulse_width_frame_decoder (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [15:0] pulse_width,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] humidity,
    output logic [15:0] temperature,
    output logic        frame_done
);

    logic [15:0] response_max_reg;
    logic [15:0] bit_max_reg;
    logic [15:0] one_min_reg;

    spwfd_pkg::status_t read_status_reg, read_status_next;
    logic               response_seen_reg, response_seen_next;
    spwfd_pkg::field_t  field_select_reg, field_select_next;
    logic [3:0]         bit_position_reg, bit_position_next;
    logic [15:0]        shift_word_reg, shift_word_next;
    logic [15:0]        humidity_word_reg, humidity_word_next;
    logic [15:0]        temperature_word_reg, temperature_word_next;
    logic               done_next;

    spwfd_pkg::result_t result_next;
    spwfd_pkg::result_t out_data_reg;
    spwfd_pkg::result_t skid_data_reg;
    logic               out_valid_reg;
    logic               skid_valid_reg;

    logic        in_accept;
    logic        out_take;
    logic [15:0] shift_set;
    logic [7:0]  byte_sum;

    assign in_accept = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;

    // threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            response_max_reg <= spwfd_pkg::RESPONSE_MAX_RST;
            bit_max_reg      <= spwfd_pkg::BIT_MAX_RST;
            one_min_reg      <= spwfd_pkg::ONE_MIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                spwfd_pkg::CFG_RESPONSE_MAX: response_max_reg <= cfg_data;
                spwfd_pkg::CFG_BIT_MAX:      bit_max_reg      <= cfg_data;
                spwfd_pkg::CFG_ONE_MIN:      one_min_reg      <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // current bit written into the shift word, and checksum of the data bytes
    always_comb
    begin
        shift_set                   = shift_word_reg;
        shift_set[bit_position_reg] = (pulse_width > one_min_reg);
        byte_sum = humidity_word_reg[7:0] + humidity_word_reg[15:8]
                 + temperature_word_reg[7:0] + temperature_word_reg[15:8];
    end

    // decode of one beat
    always_comb
    begin
        read_status_next      = read_status_reg;
        response_seen_next    = response_seen_reg;
        field_select_next     = field_select_reg;
        bit_position_next     = bit_position_reg;
        shift_word_next       = shift_word_reg;
        humidity_word_next    = humidity_word_reg;
        temperature_word_next = temperature_word_reg;
        done_next             = 1'b0;

        if (action)
        begin
            humidity_word_next    = '0;
            temperature_word_next = '0;
            shift_word_next       = '0;
            response_seen_next    = 1'b0;
            field_select_next     = spwfd_pkg::FLD_HUM;
            bit_position_next     = spwfd_pkg::TOP_BIT16;
            read_status_next      = spwfd_pkg::ST_READING;
        end
        else if (read_status_reg == spwfd_pkg::ST_READING)
        begin
            if (!response_seen_reg)
            begin
                if (pulse_width <= response_max_reg)
                    response_seen_next = 1'b1;
                else
                    read_status_next = spwfd_pkg::ST_ERROR;
            end
            else if (pulse_width > bit_max_reg)
            begin
                read_status_next = spwfd_pkg::ST_ERROR;
            end
            else if (bit_position_reg != 4'd0)
            begin
                shift_word_next   = shift_set;
                bit_position_next = bit_position_reg - 4'd1;
            end
            else
            begin
                // last bit of a field: store it, or check it against the checksum, and move on
                shift_word_next   = '0;
                bit_position_next = spwfd_pkg::TOP_BIT16;
                case (field_select_reg)
                    spwfd_pkg::FLD_HUM:
                    begin
                        humidity_word_next = shift_set;
                        field_select_next  = spwfd_pkg::FLD_TEMP;
                    end
                    spwfd_pkg::FLD_TEMP:
                    begin
                        temperature_word_next = shift_set;
                        field_select_next     = spwfd_pkg::FLD_CSUM;
                        bit_position_next     = spwfd_pkg::TOP_BIT8;
                    end
                    default:
                    begin
                        read_status_next  = (shift_set[7:0] == byte_sum) ?
                                            spwfd_pkg::ST_OK : spwfd_pkg::ST_ERROR;
                        field_select_next = spwfd_pkg::FLD_HUM;
                        done_next         = 1'b1;
                    end
                endcase
            end
        end

        result_next.status      = read_status_next;
        result_next.humidity    = humidity_word_next;
        result_next.temperature = temperature_word_next;
        result_next.frame_done  = done_next;
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_status_reg      <= spwfd_pkg::ST_OK;
            response_seen_reg    <= 1'b0;
            field_select_reg     <= spwfd_pkg::FLD_HUM;
            bit_position_reg     <= spwfd_pkg::TOP_BIT16;
            shift_word_reg       <= '0;
            humidity_word_reg    <= '0;
            temperature_word_reg <= '0;
        end
        else if (in_accept)
        begin
            read_status_reg      <= read_status_next;
            response_seen_reg    <= response_seen_next;
            field_select_reg     <= field_select_next;
            bit_position_reg     <= bit_position_next;
            shift_word_reg       <= shift_word_next;
            humidity_word_reg    <= humidity_word_next;
            temperature_word_reg <= temperature_word_next;
        end
    end

    // output register and skid register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_reg  <= skid_valid_reg || in_accept;
                skid_valid_reg <= 1'b0;
            end
            else if (in_accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (in_accept)
                out_data_reg <= result_next;
        end
        if (in_accept && out_valid_reg && !out_take)
            skid_data_reg <= result_next;
    end

    assign in_stall    = skid_valid_reg;
    assign out_valid   = out_valid_reg;
    assign status      = out_data_reg.status;
    assign humidity    = out_data_reg.humidity;
    assign temperature = out_data_reg.temperature;
    assign frame_done  = out_data_reg.frame_done;

endmodule
